// ===== rtl/scar_pkg.sv =====
// ----------------------------------------------------------------------------
// scar_pkg
// Shared types, register indexes, line lengths and defaults for the stereo
// damped comb and allpass reverb.
// ----------------------------------------------------------------------------
package scar_pkg;

  localparam int COMB_DEPTH_DEF    = 2048;
  localparam int ALLPASS_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF   = 24;

  localparam int COEF_W   = 15;
  localparam int CPOS_W   = 11;
  localparam int APOS_W   = 10;
  localparam int REG_IDX_W = 3;

  localparam logic [15:0] Q_ONE = 16'h8000;

  localparam logic [REG_IDX_W-1:0] REG_COMB_FEEDBACK = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DAMP_HOLD     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ALLPASS_GAIN  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DRY_GAIN      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WET_GAIN      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CROSS_MIX     = 3'd5;

  typedef struct packed {
    logic [COEF_W-1:0] comb_feedback;
    logic [COEF_W-1:0] damp_hold;
    logic [COEF_W-1:0] allpass_gain;
    logic [COEF_W-1:0] dry_gain;
    logic [COEF_W-1:0] wet_gain;
    logic [COEF_W-1:0] cross_mix;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MIX, ST_C_D, ST_C_S, ST_C_F, ST_C_G, ST_C_W,
    ST_WET, ST_A_D, ST_A_W, ST_O_1, ST_O_2, ST_O_3, ST_DONE
  } state_t;

  function automatic logic [CPOS_W-1:0] comb_len(input logic [2:0] idx);
    logic [CPOS_W-1:0] r;
    unique case (idx)
      3'd0:    r = 11'd1215;
      3'd1:    r = 11'd1293;
      3'd2:    r = 11'd1397;
      3'd3:    r = 11'd1473;
      3'd4:    r = 11'd1238;
      3'd5:    r = 11'd1316;
      3'd6:    r = 11'd1420;
      default: r = 11'd1496;
    endcase
    return r;
  endfunction

  function automatic logic [APOS_W-1:0] ap_len(input logic [1:0] idx);
    logic [APOS_W-1:0] r;
    unique case (idx)
      2'd0:    r = 10'd225;
      2'd1:    r = 10'd556;
      2'd2:    r = 10'd248;
      default: r = 10'd579;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/stereo_comb_allpass_reverb.sv =====
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb
// Stereo Schroeder reverb: cross mix, four damped feedback combs and two
// allpass stages per channel, blended with the dry signal.
//
//   channel   signals                                   transfer when
//   input     in_valid in_ready dry_left dry_right      in_valid & in_ready
//   output    out_valid out_ready out_left out_right    out_valid & out_ready
//   config    cfg_we cfg_index cfg_data                 cfg_we
//
// each item is taken only while the sequencer is idle and is finished before the
// next is accepted, one product per cycle through the single mac while it is
// enabled, and one comb or allpass line write per write step of the sequencer
// in_ready is high whenever the sequencer is idle, also while a result waits
// a finished result waits in the output register; the sequencer holds only
// if the output register is still full when the next result is done
// reset clears all lines through per-line fill flags, no clearing pass
// ----------------------------------------------------------------------------
module stereo_comb_allpass_reverb import scar_pkg::*; #(
  parameter int COMB_DEPTH    = COMB_DEPTH_DEF,
  parameter int ALLPASS_DEPTH = ALLPASS_DEPTH_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] dry_left,
  input  logic signed [SAMPLE_BITS-1:0] dry_right,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  input  logic                          cfg_we,
  input  logic [REG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_W-1:0]             cfg_data
);

  cfg_t cfg;
  logic idle, done, out_free, start;
  logic signed [SAMPLE_BITS-1:0] res_l, res_r;

  assign in_ready = idle;
  assign start    = in_valid & in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.comb_feedback <= 15'd25887;
      cfg.damp_hold     <= 15'd7864;
      cfg.allpass_gain  <= 15'd17039;
      cfg.dry_gain      <= 15'd23593;
      cfg.wet_gain      <= 15'd15729;
      cfg.cross_mix     <= 15'd8520;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COMB_FEEDBACK: cfg.comb_feedback <= cfg_data;
        REG_DAMP_HOLD:     cfg.damp_hold     <= cfg_data;
        REG_ALLPASS_GAIN:  cfg.allpass_gain  <= cfg_data;
        REG_DRY_GAIN:      cfg.dry_gain      <= cfg_data;
        REG_WET_GAIN:      cfg.wet_gain      <= cfg_data;
        REG_CROSS_MIX:     cfg.cross_mix     <= cfg_data;
        default: ;
      endcase
    end
  end

  scar_core #(
    .COMB_DEPTH    (COMB_DEPTH),
    .ALLPASS_DEPTH (ALLPASS_DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dry_l_in (dry_left),
    .dry_r_in (dry_right),
    .cfg      (cfg),
    .out_free (out_free),
    .idle     (idle),
    .done     (done),
    .res_l    (res_l),
    .res_r    (res_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_left  <= res_l;
      out_right <= res_r;
    end
  end

endmodule

// ===== rtl/scar_mac.sv =====
// ----------------------------------------------------------------------------
// scar_mac
// Shared multiply-accumulate unit: sample times Q1.15 coefficient, with the
// accumulator rounded half up back to sample scale.
// ----------------------------------------------------------------------------
module scar_mac import scar_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          clr,
  input  logic signed [SAMPLE_BITS-1:0] a,
  input  logic        [15:0]            b,
  output logic signed [SAMPLE_BITS+2:0] rnd
);

  localparam int AW = SAMPLE_BITS + 18;

  logic signed [SAMPLE_BITS+16:0] prod;
  logic signed [AW-1:0]           prod_x;
  logic signed [AW-1:0]           acc;
  logic signed [AW-1:0]           acc_r;

  assign prod   = a * $signed({1'b0, b});
  assign prod_x = AW'(prod);

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= clr ? prod_x : acc + prod_x;
    end
  end

  assign acc_r = (acc + AW'(16384)) >>> 15;
  assign rnd   = acc_r[SAMPLE_BITS+2:0];

endmodule

// ===== rtl/scar_core.sv =====
// ----------------------------------------------------------------------------
// scar_core
// Sequencer and datapath: comb and allpass delay lines in block memories,
// damping states and positions in registers, one shared MAC.
// ----------------------------------------------------------------------------
module scar_core import scar_pkg::*; #(
  parameter int COMB_DEPTH    = COMB_DEPTH_DEF,
  parameter int ALLPASS_DEPTH = ALLPASS_DEPTH_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] dry_l_in,
  input  logic signed [SAMPLE_BITS-1:0] dry_r_in,
  input  cfg_t                          cfg,
  input  logic                          out_free,
  output logic                          idle,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] res_l,
  output logic signed [SAMPLE_BITS-1:0] res_r
);

  localparam int S   = SAMPLE_BITS;
  localparam int AW  = S + 18;
  localparam int CAW = $clog2(COMB_DEPTH);
  localparam int AAW = $clog2(ALLPASS_DEPTH);

  function automatic logic signed [S-1:0] sat(input logic signed [AW-1:0] v);
    logic signed [S-1:0] r;
    if ((&v[AW-1:S-1]) || !(|v[AW-1:S-1])) begin
      r = v[S-1:0];
    end else if (v[AW-1]) begin
      r = {1'b1, {(S-1){1'b0}}};
    end else begin
      r = {1'b0, {(S-1){1'b1}}};
    end
    return r;
  endfunction

  state_t state, state_next;

  logic [2:0] k;
  logic       ch;
  logic [1:0] ci;
  logic       ai;

  logic signed [S-1:0]   dry_l, dry_r, mix_l, mix_r, filt, wet, apin;
  logic signed [S+1:0]   wsum;
  logic signed [S-1:0]   dstate [8];
  logic [CPOS_W-1:0]     cpos [8];
  logic [APOS_W-1:0]     apos [4];
  logic [7:0]            cfull;
  logic [3:0]            afull;

  logic signed [S-1:0] cmem [0:(8 << CAW)-1];
  logic signed [S-1:0] amem [0:(4 << AAW)-1];
  logic signed [S-1:0] cmem_q, amem_q;

  logic [2:0]          cidx, c_rd;
  logic [1:0]          aidx, a_rd;
  logic signed [S-1:0] c_rv, a_rv, dry_ch, mix_ch, satr;
  logic                c_we, a_we, c_wrap, a_wrap;
  logic [CAW+2:0]      c_waddr, c_raddr;
  logic [AAW+1:0]      a_waddr, a_raddr;
  logic signed [S-1:0] c_wdata, a_wdata;
  logic signed [S+1:0] wsum_q;

  logic                mac_en, mac_clr;
  logic signed [S-1:0] mac_a;
  logic [15:0]         mac_b;
  logic signed [S+2:0] rnd;
  logic signed [AW-1:0] rnd_x;
  logic [15:0]         own, dmix;

  scar_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac (
    .clk (clk),
    .en  (mac_en),
    .clr (mac_clr),
    .a   (mac_a),
    .b   (mac_b),
    .rnd (rnd)
  );

  assign own    = Q_ONE - {1'b0, cfg.cross_mix};
  assign dmix   = Q_ONE - {1'b0, cfg.damp_hold};
  assign cidx   = {ch, ci};
  assign aidx   = {ch, ai};
  assign dry_ch = ch ? dry_r : dry_l;
  assign mix_ch = ch ? mix_r : mix_l;
  assign rnd_x  = AW'(rnd);
  assign satr   = sat(rnd_x);
  assign c_rv   = cfull[cidx] ? cmem_q : '0;
  assign a_rv   = afull[aidx] ? amem_q : '0;
  assign idle   = (state == ST_IDLE);

  assign c_we    = (state == ST_C_W);
  assign a_we    = (state == ST_A_W);
  assign c_waddr = {cidx, CAW'(cpos[cidx])};
  assign c_raddr = {c_rd, CAW'(cpos[c_rd])};
  assign a_waddr = {aidx, AAW'(apos[aidx])};
  assign a_raddr = {a_rd, AAW'(apos[a_rd])};
  assign c_wdata = sat(AW'(mix_ch) + rnd_x);
  assign a_wdata = sat(AW'(apin) + rnd_x);
  assign c_wrap  = (cpos[cidx] + 11'd1 == comb_len(cidx));
  assign a_wrap  = (apos[aidx] + 10'd1 == ap_len(aidx));
  assign wsum_q  = (wsum + $signed((S+2)'(2))) >>> 2;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_MIX;
      ST_MIX:  if (k == 3'd4) state_next = ST_C_D;
      ST_C_D:  state_next = ST_C_S;
      ST_C_S:  state_next = ST_C_F;
      ST_C_F:  state_next = ST_C_G;
      ST_C_G:  state_next = ST_C_W;
      ST_C_W:  state_next = (ci == 2'd3) ? ST_WET : ST_C_D;
      ST_WET:  state_next = ST_A_D;
      ST_A_D:  state_next = ST_A_W;
      ST_A_W:  state_next = ai ? ST_O_1 : ST_A_D;
      ST_O_1:  state_next = ST_O_2;
      ST_O_2:  state_next = ST_O_3;
      ST_O_3:  state_next = ch ? ST_DONE : ST_C_D;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // mac control and read addresses
  always_comb begin
    mac_en  = 1'b0;
    mac_clr = 1'b0;
    mac_a   = dry_l;
    mac_b   = own;
    c_rd    = cidx;
    a_rd    = aidx;
    done    = 1'b0;
    unique case (state)
      ST_MIX: begin
        case (k)
          3'd0: begin
            mac_en = 1'b1; mac_clr = 1'b1; mac_a = dry_l; mac_b = own;
          end
          3'd1: begin
            mac_en = 1'b1; mac_a = dry_r; mac_b = {1'b0, cfg.cross_mix};
          end
          3'd2: begin
            mac_en = 1'b1; mac_clr = 1'b1; mac_a = dry_r; mac_b = own;
          end
          3'd3: begin
            mac_en = 1'b1; mac_a = dry_l; mac_b = {1'b0, cfg.cross_mix};
          end
          default: ;
        endcase
      end
      ST_C_D: begin
        mac_en = 1'b1; mac_clr = 1'b1; mac_a = c_rv; mac_b = dmix;
      end
      ST_C_S: begin
        mac_en = 1'b1; mac_a = dstate[cidx]; mac_b = {1'b0, cfg.damp_hold};
      end
      ST_C_G: begin
        mac_en = 1'b1; mac_clr = 1'b1; mac_a = filt; mac_b = {1'b0, cfg.comb_feedback};
      end
      ST_C_W: c_rd = {ch, ci + 2'd1};
      ST_A_D: begin
        mac_en = 1'b1; mac_clr = 1'b1; mac_a = a_rv; mac_b = {1'b0, cfg.allpass_gain};
      end
      ST_A_W: a_rd = {ch, 1'b1};
      ST_O_1: begin
        mac_en = 1'b1; mac_clr = 1'b1; mac_a = dry_ch; mac_b = {1'b0, cfg.dry_gain};
      end
      ST_O_2: begin
        mac_en = 1'b1; mac_a = wet; mac_b = {1'b0, cfg.wet_gain};
      end
      ST_O_3:  c_rd = 3'b100;
      ST_DONE: done = out_free;
      default: ;
    endcase
  end

  // delay line memories
  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    cmem_q <= cmem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[a_waddr] <= a_wdata;
    end
    amem_q <= amem[a_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
      ch    <= 1'b0;
      ci    <= '0;
      ai    <= 1'b0;
      cfull <= '0;
      afull <= '0;
      for (int i = 0; i < 8; i++) begin
        cpos[i]   <= '0;
        dstate[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        apos[i] <= '0;
      end
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          k  <= '0;
          ch <= 1'b0;
          ci <= '0;
        end
        ST_MIX: k <= k + 3'd1;
        ST_C_F: dstate[cidx] <= satr;
        ST_C_W: begin
          cpos[cidx] <= c_wrap ? '0 : cpos[cidx] + 11'd1;
          if (c_wrap) cfull[cidx] <= 1'b1;
          ci <= ci + 2'd1;
        end
        ST_WET: ai <= 1'b0;
        ST_A_W: begin
          apos[aidx] <= a_wrap ? '0 : apos[aidx] + 10'd1;
          if (a_wrap) afull[aidx] <= 1'b1;
          ai <= ~ai;
        end
        ST_O_3: begin
          ch <= 1'b1;
          ci <= '0;
        end
        default: ;
      endcase
    end
  end

  // sample datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (start) begin
        dry_l <= dry_l_in;
        dry_r <= dry_r_in;
      end
      ST_MIX: begin
        if (k == 3'd2) mix_l <= satr;
        if (k == 3'd4) begin
          mix_r <= satr;
          wsum  <= '0;
        end
      end
      ST_C_D: wsum <= wsum + (S+2)'(c_rv);
      ST_C_F: filt <= satr;
      ST_WET: wet <= sat(AW'(wsum_q));
      ST_A_D: begin
        apin <= wet;
        wet  <= sat(AW'(a_rv) - AW'(wet));
      end
      ST_O_3: begin
        if (ch) res_r <= satr;
        else    res_l <= satr;
        wsum <= '0;
      end
      default: ;
    endcase
  end

endmodule
